@@ rtl/pb_pkg.sv @@
// Shared types and constants for the palette builder/indexer.
package pb_pkg;

	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned COLOR_W      = 3 * CHAN_W;
	localparam int unsigned INDEX_W      = 8;
	localparam int unsigned COUNT_W      = 9;
	localparam int unsigned MAX_DEPTH    = 256;
	localparam int unsigned IN_TDATA_W   = 24;
	localparam int unsigned OUT_TDATA_W  = 24;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Pixel beat as it walks down the cell chain
	typedef struct packed {
		logic   valid;
		color_t color;
		logic   last;
		logic   found;
		index_t index;
		logic   fresh;
		count_t count;
	} beat_t;

endpackage

@@ rtl/pb_cell.sv @@
// One palette cell: holds one entry, matches or claims it, and passes the beat on.
module pb_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  pb_pkg::beat_t beat_in,
	output pb_pkg::beat_t beat_out
);
	import pb_pkg::*;

	color_t entry_q;
	logic   used_q;
	logic   valid_q;
	beat_t  beat_q;
	beat_t  beat_d;
	logic   hit;
	logic   claim;

	assign hit   = used_q && (entry_q == beat_in.color) && !beat_in.found;
	assign claim = !used_q && !beat_in.found;

	always_comb begin
		beat_d       = beat_in;
		beat_d.found = beat_in.found | hit | claim;
		beat_d.fresh = beat_in.fresh | claim;
		beat_d.index = (hit || claim) ? INDEX_W'(CELL_IDX) : beat_in.index;
		beat_d.count = beat_in.count + count_t'(used_q | claim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= beat_in.valid;
			if (beat_in.valid) begin
				used_q <= beat_in.last ? 1'b0 : (used_q | claim);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q <= beat_d;
			if (beat_in.valid && claim) begin
				entry_q <= beat_in.color;
			end
		end
	end

	always_comb begin
		beat_out       = beat_q;
		beat_out.valid = valid_q;
	end

endmodule

@@ rtl/pb_out.sv @@
// Result register: sticky overflow tracking and output beat formatting.
module pb_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pb_pkg::beat_t                      beat_in,
	output logic                               advance,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pb_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import pb_pkg::*;

	logic   ovf_q;
	logic   valid_q;
	logic   ovf_now;
	index_t index_q;
	logic   fresh_q;
	logic   ovfout_q;
	count_t count_q;

	assign advance = !valid_q || m_tready;
	assign ovf_now = ovf_q || !beat_in.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			valid_q <= beat_in.valid;
			if (beat_in.valid) begin
				ovf_q <= beat_in.last ? 1'b0 : ovf_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_in.valid) begin
			index_q  <= ovf_now ? '0 : beat_in.index;
			fresh_q  <= ovf_now ? 1'b0 : beat_in.fresh;
			ovfout_q <= ovf_now;
			count_q  <= beat_in.count;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {
		(OUT_TDATA_W - INDEX_W - 2 - COUNT_W)'(0), count_q, ovfout_q, fresh_q, index_q
	};

endmodule

@@ rtl/palette_builder_indexer_core.sv @@
// Top level of the exact-color palette builder and indexer.
// Each pixel walks a chain of PALETTE_DEPTH cells, one cell per cycle while
// not stalled; a cell holding the pixel's color supplies its index, the first
// empty cell takes the color as a new entry. One pixel is accepted per cycle
// unless the result side stalls; a result passes the register of each cell and
// then the result register, the chain length setting the latency. A stall on
// the result side holds the whole chain. The last pixel of an image empties
// each cell as it passes and clears the overflow flag at the result register.
module palette_builder_indexer_core #(
	parameter int unsigned PALETTE_DEPTH = pb_pkg::MAX_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pb_pkg::IN_TDATA_W-1:0]   s_tdata,  // blue, green, red
	input  logic                            s_tlast,  // last_pixel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pb_pkg::OUT_TDATA_W-1:0]  m_tdata   // color_index, is_new_entry,
	                                                  // overflowed, palette_count
);
	import pb_pkg::*;

	beat_t beat [PALETTE_DEPTH+1];
	logic  advance;

	assign s_tready = advance;

	always_comb begin
		beat[0]       = '0;
		beat[0].valid = s_tvalid;
		beat[0].color = {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
		beat[0].last  = s_tlast;
	end

	for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
		pb_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.beat_in (beat[k]),
			.beat_out(beat[k+1])
		);
	end

	pb_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_in (beat[PALETTE_DEPTH]),
		.advance (advance),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
